// ===== rtl/core/pkp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pad and keyboard port package
// Shared codes, masks and widths for the controller port unit.
// ----------------------------------------------------------------------------
package pkp_pkg;

    localparam int KEY_ROW_W = 4;
    localparam int KEY_ROWS  = 9;
    localparam int KEY_BITS  = KEY_ROW_W * KEY_ROWS;
    localparam int ROW_W     = 4;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;
    localparam logic PORT_0    = 1'b0;
    localparam logic PORT_1    = 1'b1;

    localparam logic [2:0] CMD_ROW_STEP    = 3'h4;
    localparam logic [2:0] CMD_ROW_CLEAR   = 3'h5;
    localparam logic [2:0] CMD_HALF_TOGGLE = 3'h6;

    localparam logic [7:0] PAD_RESET      = 8'hff;
    localparam logic [7:0] PAD2_MASK      = 8'hf3;
    localparam logic [7:0] PORT1_READ_SET = 8'hfe;

    typedef logic [KEY_BITS-1:0]  t_keys;
    typedef logic [KEY_ROW_W-1:0] t_nibble;
    typedef logic [ROW_W-1:0]     t_row;

    typedef struct packed {
        logic half;
        t_row row;
    } t_scan;

endpackage

// ===== rtl/core/pkp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pad and keyboard port channels
// Valid/ready channels for port accesses and their results.
// ----------------------------------------------------------------------------
interface pkp_in_if;
    logic           valid;
    logic           ready;
    logic           action;
    logic           port_select;
    logic [7:0]     write_data;
    logic [7:0]     pad1_buttons;
    logic [7:0]     pad2_buttons;
    pkp_pkg::t_keys keys_half_one;
    pkp_pkg::t_keys keys_half_zero;
    logic           tape_in;
    logic           mic_in;

    modport source (
        output valid, action, port_select, write_data, pad1_buttons, pad2_buttons,
               keys_half_one, keys_half_zero, tape_in, mic_in,
        input  ready
    );
    modport sink (
        input  valid, action, port_select, write_data, pad1_buttons, pad2_buttons,
               keys_half_one, keys_half_zero, tape_in, mic_in,
        output ready
    );
endinterface

interface pkp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       tape_out;

    modport source (output valid, read_data, tape_out, input ready);
    modport sink (input valid, read_data, tape_out, output ready);
endinterface

// ===== rtl/core/pad_and_keyboard_port_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pad and keyboard port unit
// Two controller ports: joypad strobe and shift, keyboard row scan, tape I/O.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  i_in    | in  | one port access (read or write, port, data, host levels)
//  o_out   | out | one result (read_data, tape_out)
//
// An access goes through an input register, then the state update and result
// register. One access is accepted every cycle while results are taken. While
// a result is stalled, the input register takes one more beat if it is empty
// and then holds the input off until the result is taken.
// Reset clears the pads to all ones, the strobe, the row scan, the half flag
// and the tape level.
// ----------------------------------------------------------------------------
module pad_and_keyboard_port_unit #(
    parameter int ROW_COUNT = 9
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pkp_in_if.sink    i_in,
    pkp_out_if.source o_out
);

    logic           r_in_valid;
    logic           r_in_action;
    logic           r_in_port;
    logic [7:0]     r_in_data;
    logic [7:0]     r_in_pad1;
    logic [7:0]     r_in_pad2;
    pkp_pkg::t_keys r_in_keys_one;
    pkp_pkg::t_keys r_in_keys_zero;
    logic           r_in_tape;
    logic           r_in_mic;

    logic           r_strobe_armed;
    logic [7:0]     r_pad1_shift;
    logic [7:0]     r_pad2_shift;
    pkp_pkg::t_scan r_scan;
    logic           r_tape_level;

    logic           n_strobe_armed;
    logic [7:0]     n_pad1_shift;
    logic [7:0]     n_pad2_shift;
    pkp_pkg::t_scan n_scan;
    logic           n_tape_level;
    logic [7:0]     n_read_data;

    logic           r_out_valid;
    logic [7:0]     r_out_read_data;
    logic           r_out_tape;

    logic             w_advance;
    logic [pkp_pkg::ROW_W:0] w_row_sum;
    logic [2:0]       w_cmd;
    pkp_pkg::t_nibble w_pressed;

    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_read_data;
    assign o_out.tape_out  = r_out_tape;

    pkp_key_row u_key_row (
        .i_scan          (r_scan),
        .i_keys_half_one (r_in_keys_one),
        .i_keys_half_zero(r_in_keys_zero),
        .o_pressed       (w_pressed)
    );

    assign w_cmd     = r_in_data[2:0];
    assign w_row_sum = {1'b0, r_scan.row} + (pkp_pkg::ROW_W + 1)'(1);

    always_comb begin
        n_strobe_armed = r_strobe_armed;
        n_pad1_shift   = r_pad1_shift;
        n_pad2_shift   = r_pad2_shift;
        n_scan         = r_scan;
        n_tape_level   = r_tape_level;
        n_read_data    = '0;
        if (r_in_action == pkp_pkg::ACT_WRITE) begin
            if (r_in_port == pkp_pkg::PORT_0) begin
                if (r_in_data[0]) begin
                    n_strobe_armed = 1'b1;
                end else if (r_strobe_armed) begin
                    n_strobe_armed = 1'b0;
                    n_pad1_shift   = {r_in_pad1[3:0], r_in_pad1[7:4]};
                    n_pad2_shift   = {r_in_pad2[3:0], r_in_pad2[7:4]} & pkp_pkg::PAD2_MASK;
                end
                unique case (w_cmd)
                    pkp_pkg::CMD_ROW_STEP: begin
                        if (w_row_sum > (pkp_pkg::ROW_W + 1)'(ROW_COUNT) ||
                            w_row_sum[pkp_pkg::ROW_W]) begin
                            n_scan.row = '0;
                        end else begin
                            n_scan.row = w_row_sum[pkp_pkg::ROW_W-1:0];
                        end
                        n_scan.half = !r_scan.half;
                    end
                    pkp_pkg::CMD_ROW_CLEAR: begin
                        n_scan.row  = '0;
                        n_scan.half = 1'b0;
                    end
                    pkp_pkg::CMD_HALF_TOGGLE: begin
                        n_scan.half = !r_scan.half;
                    end
                    default: begin
                        n_scan = r_scan;
                    end
                endcase
                n_tape_level = r_in_data[1];
            end
        end else if (r_in_port == pkp_pkg::PORT_0) begin
            n_read_data  = {5'b0, r_in_mic, r_in_tape, r_pad1_shift[0]};
            n_pad1_shift = {1'b0, r_pad1_shift[7:1]};
        end else begin
            n_read_data  = (pkp_pkg::PORT1_READ_SET | {7'b0, r_pad2_shift[0]}) &
                           ~{3'b0, w_pressed, 1'b0};
            n_pad2_shift = {1'b0, r_pad2_shift[7:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_strobe_armed <= 1'b0;
            r_pad1_shift   <= pkp_pkg::PAD_RESET;
            r_pad2_shift   <= pkp_pkg::PAD_RESET;
            r_scan         <= '0;
            r_tape_level   <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            r_out_valid <= w_advance || (r_out_valid && !o_out.ready);
            if (w_advance) begin
                r_strobe_armed <= n_strobe_armed;
                r_pad1_shift   <= n_pad1_shift;
                r_pad2_shift   <= n_pad2_shift;
                r_scan         <= n_scan;
                r_tape_level   <= n_tape_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_action    <= i_in.action;
            r_in_port      <= i_in.port_select;
            r_in_data      <= i_in.write_data;
            r_in_pad1      <= i_in.pad1_buttons;
            r_in_pad2      <= i_in.pad2_buttons;
            r_in_keys_one  <= i_in.keys_half_one;
            r_in_keys_zero <= i_in.keys_half_zero;
            r_in_tape      <= i_in.tape_in;
            r_in_mic       <= i_in.mic_in;
        end
        if (w_advance) begin
            r_out_read_data <= n_read_data;
            r_out_tape      <= n_tape_level;
        end
    end

endmodule

// ===== rtl/core/pkp_key_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard row select
// Picks the pressed-key nibble of the scanned row from the selected half.
// ----------------------------------------------------------------------------
module pkp_key_row (
    input  pkp_pkg::t_scan   i_scan,
    input  pkp_pkg::t_keys   i_keys_half_one,
    input  pkp_pkg::t_keys   i_keys_half_zero,
    output pkp_pkg::t_nibble o_pressed
);

    pkp_pkg::t_keys w_keys;

    assign w_keys = i_scan.half ? i_keys_half_one : i_keys_half_zero;

    // Row zero and rows past the last wired row read as no key pressed.
    always_comb begin
        o_pressed = '0;
        for (int r = 1; r <= pkp_pkg::KEY_ROWS; r++) begin
            if (i_scan.row == pkp_pkg::ROW_W'(r)) begin
                o_pressed = w_keys[pkp_pkg::KEY_ROW_W*(r-1) +: pkp_pkg::KEY_ROW_W];
            end
        end
    end

endmodule

// ===== rtl/core/pkp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pad and keyboard port checker
// Port-level properties of the port unit, bound into the port unit module.
// ----------------------------------------------------------------------------
module pkp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_read_data,
    input logic       i_out_tape_out
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_read_data) && $stable(i_out_tape_out))
        else $error("result payload changed while stalled");

    // The top three bits are never mixed: all set for a port 1 read, clear otherwise.
    a_top_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_read_data[7:5] == 3'b000 ||
                         i_out_read_data[7:5] == 3'b111))
        else $error("read data upper bits mixed");

    // A port 0 read or a write never drives bits 4 and 3.
    a_low_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_read_data[7:5] == 3'b000 |->
            i_out_read_data[4:3] == 2'b00)
        else $error("port 0 read data has stray bits");

endmodule

bind pad_and_keyboard_port_unit pkp_checker u_pkp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_read_data(o_out.read_data),
    .i_out_tape_out (o_out.tape_out)
);
